FILE: design/qrm_pkg.sv
// Shared constants for the quaternion to rotation matrix core.
// Used by qrm_front, qrm_divider and the top level; depends on nothing.
`default_nettype none
package qrm_pkg;
    // Default width of one quaternion component.
    localparam int QRM_IN_WIDTH  = 16;
    // Default number of fraction bits of a matrix element.
    localparam int QRM_FRAC_BITS = 14;
    // Elements of a 3x3 matrix, row-major.
    localparam int QRM_ELEMS     = 9;
endpackage
`default_nettype wire

FILE: design/qrm_front.sv
// Front end of the core: input register, ten products, the norm and the nine
// signed numerators, then sign and magnitude. Depends on qrm_pkg.
`default_nettype none
module qrm_front #(
    parameter int IN_WIDTH = qrm_pkg::QRM_IN_WIDTH
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_en,
    input  wire logic                                    i_valid,
    input  wire logic signed [IN_WIDTH-1:0]              i_qw,
    input  wire logic signed [IN_WIDTH-1:0]              i_qx,
    input  wire logic signed [IN_WIDTH-1:0]              i_qy,
    input  wire logic signed [IN_WIDTH-1:0]              i_qz,
    output logic                                         o_valid,
    output logic                                         o_zero,
    output logic [2*IN_WIDTH:0]                          o_n,
    output logic [qrm_pkg::QRM_ELEMS-1:0]                o_neg,
    output logic [qrm_pkg::QRM_ELEMS-1:0][2*IN_WIDTH:0]  o_mag
);
    import qrm_pkg::*;

    localparam int PW = 2 * IN_WIDTH;
    localparam int NW = PW + 1;
    localparam int SW = NW + 1;

    // Stage 1: input register.
    logic                       r_s1_valid;
    logic signed [IN_WIDTH-1:0] r_qw, r_qx, r_qy, r_qz;

    // Stage 2: products.
    logic                 r_s2_valid;
    logic signed [PW-1:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_yz, r_zx, r_xw, r_yw, r_zw;

    // Stage 3: norm and numerators.
    logic                 r_s3_valid;
    logic [NW-1:0]        r_n3;
    logic signed [SW-1:0] r_num [QRM_ELEMS];

    // Stage 4: sign and magnitude.
    logic                 r_s4_valid;
    logic                 r_zero;
    logic [NW-1:0]        r_n4;
    logic [QRM_ELEMS-1:0] r_neg;
    logic [QRM_ELEMS-1:0][NW-1:0] r_mag;

    logic signed [SW-1:0] n_ww, n_xx, n_yy, n_zz, n_xy, n_yz, n_zx, n_xw, n_yw, n_zw;
    logic [NW-1:0]        n_n;
    logic signed [SW-1:0] n_num [QRM_ELEMS];

    always_comb begin
        n_ww = {{(SW-PW){r_ww[PW-1]}}, r_ww};
        n_xx = {{(SW-PW){r_xx[PW-1]}}, r_xx};
        n_yy = {{(SW-PW){r_yy[PW-1]}}, r_yy};
        n_zz = {{(SW-PW){r_zz[PW-1]}}, r_zz};
        n_xy = {{(SW-PW){r_xy[PW-1]}}, r_xy};
        n_yz = {{(SW-PW){r_yz[PW-1]}}, r_yz};
        n_zx = {{(SW-PW){r_zx[PW-1]}}, r_zx};
        n_xw = {{(SW-PW){r_xw[PW-1]}}, r_xw};
        n_yw = {{(SW-PW){r_yw[PW-1]}}, r_yw};
        n_zw = {{(SW-PW){r_zw[PW-1]}}, r_zw};
        // Squares are never negative, so their top bit is clear.
        n_n  = {1'b0, r_ww} + {1'b0, r_xx} + {1'b0, r_yy} + {1'b0, r_zz};
        // Off-diagonal numerators carry their factor of two here, so every
        // element divides a magnitude no larger than the norm.
        n_num[0] = n_ww + n_xx - n_yy - n_zz;
        n_num[1] = (n_xy - n_zw) <<< 1;
        n_num[2] = (n_zx + n_yw) <<< 1;
        n_num[3] = (n_xy + n_zw) <<< 1;
        n_num[4] = n_ww + n_yy - n_xx - n_zz;
        n_num[5] = (n_yz - n_xw) <<< 1;
        n_num[6] = (n_zx - n_yw) <<< 1;
        n_num[7] = (n_yz + n_xw) <<< 1;
        n_num[8] = n_ww + n_zz - n_xx - n_yy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qw <= i_qw;
            r_qx <= i_qx;
            r_qy <= i_qy;
            r_qz <= i_qz;

            r_ww <= PW'(r_qw) * PW'(r_qw);
            r_xx <= PW'(r_qx) * PW'(r_qx);
            r_yy <= PW'(r_qy) * PW'(r_qy);
            r_zz <= PW'(r_qz) * PW'(r_qz);
            r_xy <= PW'(r_qx) * PW'(r_qy);
            r_yz <= PW'(r_qy) * PW'(r_qz);
            r_zx <= PW'(r_qz) * PW'(r_qx);
            r_xw <= PW'(r_qx) * PW'(r_qw);
            r_yw <= PW'(r_qy) * PW'(r_qw);
            r_zw <= PW'(r_qz) * PW'(r_qw);

            r_n3 <= n_n;
            for (int e = 0; e < QRM_ELEMS; e++) begin
                r_num[e] <= n_num[e];
            end

            r_n4   <= r_n3;
            r_zero <= (r_n3 == '0);
            for (int e = 0; e < QRM_ELEMS; e++) begin
                r_neg[e] <= r_num[e][SW-1];
                r_mag[e] <= r_num[e][SW-1] ? NW'(-r_num[e]) : NW'(r_num[e]);
            end
        end
    end

    assign o_valid = r_s4_valid;
    assign o_zero  = r_zero;
    assign o_n     = r_n4;
    assign o_neg   = r_neg;
    assign o_mag   = r_mag;
endmodule
`default_nettype wire

FILE: design/qrm_divider.sv
// Nine-lane pipelined restoring divider, one quotient bit per stage, followed
// by rounding, clamping and sign restore into the output register. Depends on qrm_pkg.
`default_nettype none
module qrm_divider #(
    parameter int IN_WIDTH  = qrm_pkg::QRM_IN_WIDTH,
    parameter int FRAC_BITS = qrm_pkg::QRM_FRAC_BITS
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_en,
    input  wire logic                                          i_valid,
    input  wire logic                                          i_zero,
    input  wire logic [2*IN_WIDTH:0]                           i_n,
    input  wire logic [qrm_pkg::QRM_ELEMS-1:0]                 i_neg,
    input  wire logic [qrm_pkg::QRM_ELEMS-1:0][2*IN_WIDTH:0]   i_mag,
    output logic                                               o_valid,
    output logic                                               o_zero,
    output logic [qrm_pkg::QRM_ELEMS-1:0][FRAC_BITS+1:0]       o_m
);
    import qrm_pkg::*;

    localparam int NW    = 2 * IN_WIDTH + 1;
    localparam int RW    = NW + 1;
    localparam int STEPS = FRAC_BITS + 1;
    localparam int QW    = FRAC_BITS + 1;
    localparam int OW    = FRAC_BITS + 2;
    localparam logic [OW-1:0]        ONE_Q = OW'(1) << FRAC_BITS;
    localparam logic [QRM_ELEMS-1:0] DIAG  = QRM_ELEMS'(9'b100010001);

    logic [RW-1:0]        r_rem   [STEPS][QRM_ELEMS];
    logic [QW-1:0]        r_q     [STEPS][QRM_ELEMS];
    logic [QRM_ELEMS-1:0] r_neg   [STEPS];
    logic [NW-1:0]        r_n     [STEPS];
    logic                 r_zero  [STEPS];
    logic [STEPS-1:0]     r_valid;

    logic                         r_out_valid;
    logic                         r_out_zero;
    logic [QRM_ELEMS-1:0][OW-1:0] r_m;

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        logic [NW-1:0]        s_n;
        logic [QRM_ELEMS-1:0] s_neg;
        logic                 s_zero;
        logic                 s_valid;

        if (j == 0) begin : g_first
            assign s_n     = i_n;
            assign s_neg   = i_neg;
            assign s_zero  = i_zero;
            assign s_valid = i_valid;
        end else begin : g_next
            assign s_n     = r_n[j-1];
            assign s_neg   = r_neg[j-1];
            assign s_zero  = r_zero[j-1];
            assign s_valid = r_valid[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_valid[j] <= s_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[j]    <= s_n;
                r_neg[j]  <= s_neg;
                r_zero[j] <= s_zero;
            end
        end

        for (genvar e = 0; e < QRM_ELEMS; e++) begin : g_lane
            logic [RW-1:0] s_sh;
            logic [QW-1:0] s_qs;
            logic          s_ge;

            // The first step compares the unshifted magnitude; each later
            // step doubles the partial remainder first.
            if (j == 0) begin : g_first
                assign s_sh = {1'b0, i_mag[e]};
                assign s_qs = '0;
            end else begin : g_next
                assign s_sh = {r_rem[j-1][e][RW-2:0], 1'b0};
                assign s_qs = {r_q[j-1][e][QW-2:0], 1'b0};
            end

            assign s_ge = (s_sh >= {1'b0, s_n});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j][e] <= s_ge ? (s_sh - {1'b0, s_n}) : s_sh;
                    r_q[j][e]   <= s_qs | QW'(s_ge);
                end
            end
        end
    end

    for (genvar e = 0; e < QRM_ELEMS; e++) begin : g_out
        logic          s_up;
        logic [OW-1:0] s_qr;
        logic [OW-1:0] s_sat;
        logic [OW-1:0] n_m;

        // Round half up in magnitude: compare twice the remainder to the norm.
        assign s_up  = ({r_rem[STEPS-1][e][RW-2:0], 1'b0} >= {1'b0, r_n[STEPS-1]});
        assign s_qr  = {1'b0, r_q[STEPS-1][e]} + OW'(s_up);
        assign s_sat = (s_qr > ONE_Q) ? ONE_Q : s_qr;

        always_comb begin
            if (r_zero[STEPS-1]) begin
                n_m = DIAG[e] ? ONE_Q : '0;
            end else if (r_neg[STEPS-1][e]) begin
                n_m = -s_sat;
            end else begin
                n_m = s_sat;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[e] <= n_m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_valid[STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_zero <= r_zero[STEPS-1];
        end
    end

    assign o_valid = r_out_valid;
    assign o_zero  = r_out_zero;
    assign o_m     = r_m;
endmodule
`default_nettype wire

FILE: design/quaternion_to_rotation_matrix_core.sv
// Input to output: front-end stages, divider bit stages, output register.
// Throughput: one quaternion per cycle unless the output stalls; the whole pipeline advances together.
// The depth is set by the divider, which produces one quotient bit per stage.
// Reset (synchronous, active low) clears every stage valid bit; data is not reset.
`default_nettype none
module quaternion_to_rotation_matrix_core #(
    parameter int IN_WIDTH  = qrm_pkg::QRM_IN_WIDTH,
    parameter int FRAC_BITS = qrm_pkg::QRM_FRAC_BITS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Input channel.
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic signed [IN_WIDTH-1:0] i_qw,
    input  wire logic signed [IN_WIDTH-1:0] i_qx,
    input  wire logic signed [IN_WIDTH-1:0] i_qy,
    input  wire logic signed [IN_WIDTH-1:0] i_qz,
    // Output channel.
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic signed [FRAC_BITS+1:0]     o_m00,
    output logic signed [FRAC_BITS+1:0]     o_m01,
    output logic signed [FRAC_BITS+1:0]     o_m02,
    output logic signed [FRAC_BITS+1:0]     o_m10,
    output logic signed [FRAC_BITS+1:0]     o_m11,
    output logic signed [FRAC_BITS+1:0]     o_m12,
    output logic signed [FRAC_BITS+1:0]     o_m20,
    output logic signed [FRAC_BITS+1:0]     o_m21,
    output logic signed [FRAC_BITS+1:0]     o_m22,
    output logic                            o_zero_norm
);
    import qrm_pkg::*;

    localparam int NW = 2 * IN_WIDTH + 1;
    localparam int OW = FRAC_BITS + 2;

    // The pipeline holds as a whole only while a finished result sits in the
    // output register and the downstream side refuses the transfer. Every
    // stage keeps its valid bit and data, so nothing is lost or repeated, and
    // empty slots ahead of the output keep filling whenever the output moves.
    logic                         s_en;
    logic                         s_f_valid;
    logic                         s_f_zero;
    logic [NW-1:0]                s_f_n;
    logic [QRM_ELEMS-1:0]         s_f_neg;
    logic [QRM_ELEMS-1:0][NW-1:0] s_f_mag;
    logic [QRM_ELEMS-1:0][OW-1:0] s_m;

    assign s_en    = !(o_valid && i_stall);
    assign o_stall = !s_en;

    // Input register, products, norm and numerators, sign and magnitude: four register stages.
    qrm_front #(
        .IN_WIDTH (IN_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_valid (i_valid),
        .i_qw    (i_qw),
        .i_qx    (i_qx),
        .i_qy    (i_qy),
        .i_qz    (i_qz),
        .o_valid (s_f_valid),
        .o_zero  (s_f_zero),
        .o_n     (s_f_n),
        .o_neg   (s_f_neg),
        .o_mag   (s_f_mag)
    );

    // Division by the norm, FRAC_BITS + 1 bit stages, then the rounding stage
    // that is also the output register. A zero quaternion leaves the identity.
    qrm_divider #(
        .IN_WIDTH  (IN_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_valid (s_f_valid),
        .i_zero  (s_f_zero),
        .i_n     (s_f_n),
        .i_neg   (s_f_neg),
        .i_mag   (s_f_mag),
        .o_valid (o_valid),
        .o_zero  (o_zero_norm),
        .o_m     (s_m)
    );

    assign o_m00 = s_m[0];
    assign o_m01 = s_m[1];
    assign o_m02 = s_m[2];
    assign o_m10 = s_m[3];
    assign o_m11 = s_m[4];
    assign o_m12 = s_m[5];
    assign o_m20 = s_m[6];
    assign o_m21 = s_m[7];
    assign o_m22 = s_m[8];
endmodule
`default_nettype wire

FILE: tb/qrm_checker.sv
// Checker for the quaternion to rotation matrix core: watches both channels,
// predicts each matrix from the accepted quaternion and compares. Uses qrm_pkg.
`timescale 1ns / 100ps
module qrm_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic signed [15:0] i_qw,
    input  logic signed [15:0] i_qx,
    input  logic signed [15:0] i_qy,
    input  logic signed [15:0] i_qz,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [15:0] o_m [qrm_pkg::QRM_ELEMS],
    input  logic               o_zero_norm,
    output int                 errors,
    output int                 pending
);
    localparam int FB = qrm_pkg::QRM_FRAC_BITS;

    typedef struct {
        logic signed [15:0] m [qrm_pkg::QRM_ELEMS];
        logic               zn;
    } matrix_t;

    matrix_t expected_matrices[$];

    // Rounded num * 2^sh / n, ties away from zero, clamped to one.
    function automatic logic signed [15:0] ratio_q(longint num, longint n, int sh);
        longint mag;
        longint q;
        logic   neg;
        neg = num < 0;
        mag = neg ? -num : num;
        q = ((mag <<< (sh + 1)) / n + 1) >>> 1;
        if (q > (64'sd1 <<< FB)) q = 64'sd1 <<< FB;
        return 16'(neg ? -q : q);
    endfunction

    function automatic matrix_t rotation_of(longint w, longint x, longint y, longint z);
        matrix_t r;
        longint  n;
        n = w * w + x * x + y * y + z * z;
        r.zn = (n == 0);
        if (n == 0) begin
            foreach (r.m[k]) r.m[k] = '0;
            r.m[0] = 16'sd1 <<< FB;
            r.m[4] = 16'sd1 <<< FB;
            r.m[8] = 16'sd1 <<< FB;
            return r;
        end
        r.m[0] = ratio_q(w * w + x * x - y * y - z * z, n, FB);
        r.m[1] = ratio_q(x * y - z * w, n, FB + 1);
        r.m[2] = ratio_q(z * x + y * w, n, FB + 1);
        r.m[3] = ratio_q(x * y + z * w, n, FB + 1);
        r.m[4] = ratio_q(w * w + y * y - x * x - z * z, n, FB);
        r.m[5] = ratio_q(y * z - x * w, n, FB + 1);
        r.m[6] = ratio_q(z * x - y * w, n, FB + 1);
        r.m[7] = ratio_q(y * z + x * w, n, FB + 1);
        r.m[8] = ratio_q(w * w + z * z - x * x - y * y, n, FB);
        return r;
    endfunction

    assign pending = expected_matrices.size();

    initial errors = 0;

    always @(posedge i_clk) begin
        matrix_t exp_m;
        logic    bad;
        if (i_rst_n && i_valid && !o_stall)
            expected_matrices.push_back(rotation_of(longint'(i_qw), longint'(i_qx),
                                                    longint'(i_qy), longint'(i_qz)));
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_matrices.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result transfer at %0t", $time);
            end else begin
                exp_m = expected_matrices.pop_front();
                bad = (o_zero_norm !== exp_m.zn);
                foreach (exp_m.m[k]) if (o_m[k] !== exp_m.m[k]) bad = 1;
                if (bad) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch at %0t: zero_norm exp %0d got %0d",
                                 $time, exp_m.zn, o_zero_norm);
                        foreach (exp_m.m[k])
                            $display("  m[%0d] exp %0d got %0d", k, exp_m.m[k], o_m[k]);
                    end
                end
            end
        end
    end
endmodule

FILE: tb/tb_top.sv
// Top of the quaternion to rotation matrix testbench: clock, reset, stimulus,
// receiver stalls and the verdict. Depends on qrm_checker and the core.
`timescale 1ns / 100ps
module tb_top;
    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_stall;
    logic signed [15:0] i_qw = 0, i_qx = 0, i_qy = 0, i_qz = 0;
    logic               o_valid;
    logic               i_stall = 0;
    logic signed [15:0] o_m [qrm_pkg::QRM_ELEMS];
    logic               o_zero_norm;
    int                 errors;
    int                 pending;
    int                 idle_cycles = 0;
    logic               quiet = 0;
    logic               hold_done = 0;

    always #5 i_clk = ~i_clk;

    quaternion_to_rotation_matrix_core i_dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_qw, .i_qx, .i_qy, .i_qz,
        .o_valid, .i_stall,
        .o_m00(o_m[0]), .o_m01(o_m[1]), .o_m02(o_m[2]),
        .o_m10(o_m[3]), .o_m11(o_m[4]), .o_m12(o_m[5]),
        .o_m20(o_m[6]), .o_m21(o_m[7]), .o_m22(o_m[8]),
        .o_zero_norm
    );

    qrm_checker i_checker (.*);

    // Watchdog: a run with no transfer for this long is stuck.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles > 2000) begin
            $display("[quaternion_to_rotation_matrix_core] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Sends one quaternion and holds it until the transfer happens.
    task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z);
        i_valid <= 1;
        i_qw <= w; i_qx <= x; i_qy <= y; i_qz <= z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Draws a component: full range half the time, else a corner or a small value.
    function automatic logic [15:0] pick_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 6) - 3);
            default: return 16'($urandom());
        endcase
    endfunction

    // Receiver: random stall bursts, one long hold-off early in the run,
    // and none at all once the quiet tail of the run begins.
    initial begin
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        i_stall <= 1;
        repeat (80) @(negedge i_clk);
        i_stall <= 0;
        hold_done = 1;
        while (!quiet) begin
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
            if (!quiet) i_stall <= 1'($urandom_range(0, 1));
        end
        i_stall <= 0;
    end

    initial begin
        logic [15:0] w, x, y, z;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // Directed: zero quaternion, axes, corner values and mixed values.
        send_quat(0, 0, 0, 0);
        send_quat(1, 0, 0, 0);
        send_quat(0, 1, 0, 0);
        send_quat(0, 0, 1, 0);
        send_quat(0, 0, 0, 1);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_quat(16'hffff, 0, 0, 0);
        send_quat(1, 1, 1, 1);
        send_quat(1, 1, 0, 0);
        send_quat(3, 0, 0, 0);
        send_quat(1, 2, 3, 4);
        send_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_quat(16'h5555, 16'haaaa, 16'h0f0f, 16'hf0f0);
        send_quat(0, 0, 0, 16'h8000);
        send_quat(0, 0, 16'hffff, 16'h0001);
        // Random part; the sender keeps offering during the long hold-off.
        for (int i = 0; i < 800; i++) begin
            w = pick_comp(); x = pick_comp(); y = pick_comp(); z = pick_comp();
            if ($urandom_range(0, 40) == 0) begin
                w = 0; x = 0; y = 0; z = 0;
            end
            if (i == 700) quiet = 1;
            send_quat(w, x, y, z);
            if (hold_done && !quiet && $urandom_range(0, 5) == 0) begin
                i_valid <= 0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end
        end
        i_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        if (errors == 0) begin
            $display("[quaternion_to_rotation_matrix_core] OK");
        end else begin
            $display("[quaternion_to_rotation_matrix_core] ERROR");
        end
        $finish;
    end
endmodule
